### rtl/tct_pkg.sv
// ----------------------------------------------------------------------------
// Thermistor channel temperature package
// Shared constants and default parameters.
// ----------------------------------------------------------------------------
package tct_pkg;

  localparam int CHANNELS_DEF    = 4;
  localparam int TABLE_DEPTH_DEF = 256;
  localparam int MAX_WINDOW_DEF  = 64;

  localparam int CFG_W = 9;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEN0     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LEN1     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CHOICE   = 3'd4;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_WRITE  = 1'b1;

  localparam logic signed [12:0] TEMP_MIN = -13'sd200;
  localparam logic signed [12:0] TEMP_MAX = 13'sd4095;

endpackage

### rtl/tct_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tct_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/thermistor_channel_temperature.sv
// ----------------------------------------------------------------------------
// Thermistor channel temperature
// Per-channel trimmed window mean, table lookup with interpolation, debounce.
// ----------------------------------------------------------------------------
// A sample that does not close a window is read, updated and written back. A
// closing sample is read and updated, then runs the window divide, setup, the
// last-entry check and, where needed, the table search, low-entry read and
// interpolation divide, then clamp, debounce and write back before its result
// is offered; the search reads the calibration RAM one entry at a time. One item
// is taken at a time. Reset: synchronous; channel state RAM is cleared by a pass
// after reset, during which no item is taken. Calibration tables are not cleared.
module thermistor_channel_temperature
  import tct_pkg::*;
#(
  parameter int CHANNELS    = CHANNELS_DEF,
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int MAX_WINDOW  = MAX_WINDOW_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 op,
  input  logic [1:0]           channel,
  input  logic                 table_id,
  input  logic [7:0]           table_index,
  input  logic [9:0]           value,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           result_channel,
  output logic [9:0]           average,
  output logic signed [12:0]   measured_temp,
  output logic signed [12:0]   accepted_temp,
  output logic                 updated
);

  localparam int TA_W  = $clog2(TABLE_DEPTH);
  localparam int TM_W  = TA_W + 1;
  localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int LEN_W = $clog2(TABLE_DEPTH + 1);
  // channel record: sum16, min10, max10, count6, deb8, cmp13, held13
  localparam int ST_W  = 16 + 10 + 10 + 6 + 8 + 13 + 13;

  typedef struct packed {
    logic [15:0]        sum;
    logic [9:0]         mn;
    logic [9:0]         mx;
    logic [5:0]         cnt;
    logic [7:0]         deb;
    logic signed [12:0] cmp;
    logic signed [12:0] held;
  } chan_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_READ, S_UPD, S_FIX, S_DIV, S_SAT, S_LAST, S_LASTW, S_SRCH,
    S_SRCHW, S_LO, S_LOW, S_IDIV, S_CLAMP, S_DEB, S_OUT
  } state_t;

  state_t state;

  // configuration
  logic [6:0] window_samples;
  logic [7:0] debounce_limit;
  logic [8:0] len0, len1;
  logic [3:0] table_choice;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_samples <= 7'd8;
      debounce_limit <= 8'd100;
      len0 <= 9'd130;
      len1 <= 9'd92;
      table_choice <= 4'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WINDOW:   window_samples <= cfg_data[6:0];
        REG_DEBOUNCE: debounce_limit <= cfg_data[7:0];
        REG_LEN0:     len0 <= cfg_data;
        REG_LEN1:     len1 <= cfg_data;
        REG_CHOICE:   table_choice <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // RAMs
  logic             st_we;
  logic [CH_W-1:0]  st_waddr, st_raddr;
  chan_t            st_wdata, st_rdata;
  logic [ST_W-1:0]  st_rraw;

  tct_ram #(.WIDTH(ST_W), .DEPTH(CHANNELS < 2 ? 2 : CHANNELS)) u_state (
    .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
    .raddr(st_raddr), .rdata(st_rraw)
  );
  assign st_rdata = chan_t'(st_rraw);

  logic             tb_we;
  logic [TM_W-1:0]  tb_waddr, tb_raddr;
  logic [9:0]       tb_rdata;

  tct_ram #(.WIDTH(10), .DEPTH(2 * TABLE_DEPTH)) u_table (
    .clk(clk), .we(tb_we), .waddr(tb_waddr), .wdata(value),
    .raddr(tb_raddr), .rdata(tb_rdata)
  );

  // working registers
  logic [CH_W-1:0]  ch;
  logic [1:0]       ch2;
  logic [9:0]       val;
  chan_t            rec;
  logic [6:0]       win;
  logic [15:0]      dividend;
  logic [15:0]      quot;
  logic [16:0]      rem;
  logic [4:0]       dcnt;
  logic [9:0]       avg;
  logic             tsel;
  logic [LEN_W-1:0] n;
  logic [TA_W-1:0]  k;
  logic [9:0]       hi_v;
  logic signed [12:0] meas;
  logic [CH_W:0]    clr;

  logic [6:0]       win_c;
  logic [8:0]       len_sel;
  logic [LEN_W-1:0] n_c;
  logic [9:0]       nmn, nmx;
  logic [15:0]      nsum;

  always_comb begin
    win_c = window_samples;
    if (window_samples < 7'd3) win_c = 7'd3;
    else if (window_samples > 7'(MAX_WINDOW)) win_c = 7'(MAX_WINDOW);
    len_sel = table_choice[ch2] ? len1 : len0;
    n_c = LEN_W'(len_sel);
    if (len_sel < 9'd2) n_c = LEN_W'(2);
    else if (32'(len_sel) > TABLE_DEPTH) n_c = LEN_W'(TABLE_DEPTH);
    nmn = (rec.cnt == 6'd0 || val < rec.mn) ? val : rec.mn;
    nmx = (rec.cnt == 6'd0 || val > rec.mx) ? val : rec.mx;
    nsum = rec.sum + 16'(val);
  end

  // restoring divider step
  logic [16:0] rtry;
  always_comb rtry = {rem[15:0], dividend[15]} - 17'(win - 7'd2);

  // interpolation constants
  logic signed [12:0] kbase;
  always_comb kbase = 13'(($signed({1'b0, k}) - 13'sd21) * 13'sd10);

  assign in_ready = (state == S_IDLE);
  assign tb_we    = in_valid && in_ready && op == OP_WRITE &&
                    32'(table_index) < TABLE_DEPTH;
  assign tb_waddr = {table_id, TA_W'(table_index)};

  always_comb begin
    st_we = 1'b0;
    st_waddr = ch;
    st_wdata = rec;
    st_raddr = CH_W'(channel);
    if (state == S_CLEAR) begin
      st_we = 1'b1;
      st_waddr = clr[CH_W-1:0];
      st_wdata = '{sum: '0, mn: '0, mx: '0, cnt: '0, deb: '0,
                   cmp: -13'sd1, held: '0};
    end else if (state == S_OUT && !out_valid) begin
      st_we = 1'b1;
    end else if (state == S_FIX) begin
      st_we = 1'b1;
    end
  end

  always_comb begin
    tb_raddr = {tsel, k};
    if (state == S_LAST) tb_raddr = {tsel, TA_W'(n - LEN_W'(1))};
    else if (state == S_LO) tb_raddr = {tsel, TA_W'(k - TA_W'(1))};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (32'(clr) == CHANNELS - 1) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid && op == OP_SAMPLE) begin
            ch <= CH_W'(channel);
            ch2 <= channel;
            val <= value;
            if (32'(channel) < CHANNELS) state <= S_READ;
          end
        end
        S_READ: begin
          rec <= st_rdata;
          state <= S_UPD;
        end
        S_UPD: begin
          // st_wdata uses rec; write occurs after closing or counting below
          win <= win_c;
          if (32'(rec.cnt) + 1 < 32'(win_c)) begin
            rec.cnt <= rec.cnt + 6'd1;
            rec.mn <= nmn;
            rec.mx <= nmx;
            rec.sum <= nsum;
            state <= S_FIX;
          end else begin
            rec.cnt <= '0;
            rec.sum <= '0;
            rec.mn <= nmn;
            rec.mx <= nmx;
            dividend <= nsum - 16'(nmx) - 16'(nmn);
            rem <= '0;
            dcnt <= '0;
            state <= S_DIV;
          end
        end
        S_FIX: state <= S_IDLE;
        S_DIV: begin
          if (!rtry[16]) begin
            rem <= rtry;
            quot <= {quot[14:0], 1'b1};
          end else begin
            rem <= {rem[15:0], dividend[15]};
            quot <= {quot[14:0], 1'b0};
          end
          dividend <= {dividend[14:0], 1'b0};
          dcnt <= dcnt + 5'd1;
          if (dcnt == 5'd15) state <= S_SAT;
        end
        S_SAT: begin
          avg <= (quot > 16'd1023) ? 10'd1023 : quot[9:0];
          tsel <= table_choice[ch2];
          n <= n_c;
          k <= '0;
          state <= S_LAST;
        end
        S_LAST: state <= S_LASTW;
        S_LASTW: begin
          if (avg >= tb_rdata) begin
            meas <= 13'(($signed({1'b0, n}) - 13'sd21) * 13'sd10);
            state <= S_CLAMP;
          end else begin
            state <= S_SRCH;
          end
        end
        S_SRCH: state <= S_SRCHW;
        S_SRCHW: begin
          if (32'(k) < 32'(n) - 1 && tb_rdata < avg) begin
            k <= k + 1'b1;
            state <= S_SRCH;
          end else if (k == '0) begin
            meas <= TEMP_MIN;
            state <= S_CLAMP;
          end else begin
            hi_v <= tb_rdata;
            state <= S_LO;
          end
        end
        S_LO: state <= S_LOW;
        S_LOW: begin
          // interpolate: (avg-lo)*10 / (hi-lo), quotient at most 10
          dividend <= 16'(avg - tb_rdata) * 16'd10;
          rem <= 17'(hi_v - tb_rdata);
          quot <= '0;
          state <= S_IDIV;
        end
        S_IDIV: begin
          if (dividend >= rem[15:0]) begin
            dividend <= dividend - rem[15:0];
            quot <= quot + 16'd1;
          end else begin
            meas <= kbase + 13'(quot);
            state <= S_CLAMP;
          end
        end
        S_CLAMP: begin
          if (meas < TEMP_MIN) meas <= TEMP_MIN;
          else if (meas > TEMP_MAX) meas <= TEMP_MAX;
          state <= S_DEB;
        end
        S_DEB: begin
          updated <= 1'b0;
          if (rec.cmp != meas) begin
            rec.deb <= rec.deb + 8'd1;
            if (rec.deb > debounce_limit) begin
              rec.deb <= '0;
              rec.held <= meas;
              rec.cmp <= meas;
              updated <= 1'b1;
            end
          end else begin
            rec.deb <= '0;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          // write back this cycle, then present the result
          if (!out_valid) begin
            out_valid <= 1'b1;
            result_channel <= ch2;
            average <= avg;
            measured_temp <= meas;
            accepted_temp <= rec.held;
          end else if (out_ready) begin
            out_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### bench/tct_checker.sv
// ----------------------------------------------------------------------------
// Thermistor channel temperature checker
// Watches configuration writes and all four channels, predicts each window
// reading from its own copy of the channel state and calibration tables,
// and compares every result transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module tct_checker
  import tct_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic                 op,
  input  logic [1:0]           channel,
  input  logic                 table_id,
  input  logic [7:0]           table_index,
  input  logic [9:0]           value,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [1:0]           result_channel,
  input  logic [9:0]           average,
  input  logic signed [12:0]   measured_temp,
  input  logic signed [12:0]   accepted_temp,
  input  logic                 updated,
  output int                   errors,
  output int                   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [1:0]         ch;
    logic [9:0]         avg;
    logic signed [12:0] meas;
    logic signed [12:0] acc;
    logic               upd;
  } reading_t;

  logic [9:0]         cal_entry [0:1][0:255];
  logic [15:0]        win_sum [4];
  logic [9:0]         win_low [4];
  logic [9:0]         win_high [4];
  logic [5:0]         win_count [4];
  logic [7:0]         differ_count [4];
  logic signed [12:0] compare_t [4];
  logic signed [12:0] held_t [4];
  logic [6:0]         window_r;
  logic [7:0]         debounce_r;
  logic [8:0]         len0_r;
  logic [8:0]         len1_r;
  logic [3:0]         choice_r;
  reading_t           readings_due [$];

  initial errors = 0;
  initial pending = 0;

  function automatic logic signed [12:0] convert_mean(logic [9:0] m, logic sel,
                                                      logic [8:0] len);
    int n, k, t, lo, hi;
    n = (len < 2) ? 2 : (len > 256) ? 256 : len;
    if (m >= cal_entry[sel][n-1]) begin
      t = (n - 21) * 10;
    end else begin
      k = 0;
      while (k < n - 1 && cal_entry[sel][k] < m) k++;
      if (k == 0) return TEMP_MIN;
      lo = cal_entry[sel][k-1];
      hi = cal_entry[sel][k];
      t = (k - 21) * 10 + ((int'(m) - lo) * 10) / (hi - lo);
    end
    if (t < -200) t = -200;
    if (t > 4095) t = 4095;
    return t[12:0];
  endfunction

  task automatic absorb_item(logic o, logic [1:0] c, logic t, logic [7:0] ix,
                             logic [9:0] v);
    int w, mean;
    logic [15:0] trimmed;
    logic [7:0] old;
    reading_t r;
    if (o == OP_WRITE) begin
      cal_entry[t][ix] = v;
      return;
    end
    if (win_count[c] == 0) begin
      win_low[c] = v;
      win_high[c] = v;
    end else begin
      if (v > win_high[c]) win_high[c] = v;
      if (v < win_low[c]) win_low[c] = v;
    end
    win_sum[c] = win_sum[c] + 16'(v);
    w = (window_r < 3) ? 3 : (window_r > 64) ? 64 : window_r;
    if (win_count[c] + 1 < w) begin
      win_count[c] = win_count[c] + 6'd1;
      return;
    end
    trimmed = win_sum[c] - win_high[c] - win_low[c];
    mean = 32'(trimmed) / (w - 2);
    if (mean > 1023) mean = 1023;
    win_count[c] = 0;
    win_sum[c] = 0;
    r.meas = convert_mean(mean[9:0], choice_r[c], choice_r[c] ? len1_r : len0_r);
    r.upd = 1'b0;
    if (compare_t[c] != r.meas) begin
      old = differ_count[c];
      differ_count[c] = old + 8'd1;
      if (old > debounce_r) begin
        differ_count[c] = 0;
        held_t[c] = r.meas;
        compare_t[c] = r.meas;
        r.upd = 1'b1;
      end
    end else begin
      differ_count[c] = 0;
    end
    r.ch = c;
    r.avg = mean[9:0];
    r.acc = held_t[c];
    readings_due.push_back(r);
  endtask

  task automatic check_reading();
    reading_t r;
    if (readings_due.size() == 0) begin
      $error("unexpected result transfer: result_channel %0d", result_channel);
      errors++;
      return;
    end
    r = readings_due.pop_front();
    if (result_channel !== r.ch) begin
      $error("result_channel expected %0d actual %0d", r.ch, result_channel);
      errors++;
    end
    if (average !== r.avg) begin
      $error("average expected %0d actual %0d", r.avg, average);
      errors++;
    end
    if (measured_temp !== r.meas) begin
      $error("measured_temp expected %0d actual %0d", r.meas, measured_temp);
      errors++;
    end
    if (accepted_temp !== r.acc) begin
      $error("accepted_temp expected %0d actual %0d", r.acc, accepted_temp);
      errors++;
    end
    if (updated !== r.upd) begin
      $error("updated expected %0d actual %0d", r.upd, updated);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < 4; c++) begin
        win_sum[c] = 0;
        win_low[c] = 0;
        win_high[c] = 0;
        win_count[c] = 0;
        differ_count[c] = 0;
        compare_t[c] = -13'sd1;
        held_t[c] = 0;
      end
      window_r = 7'd8;
      debounce_r = 8'd100;
      len0_r = 9'd130;
      len1_r = 9'd92;
      choice_r = 4'd0;
      readings_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_WINDOW:   window_r = cfg_data[6:0];
          REG_DEBOUNCE: debounce_r = cfg_data[7:0];
          REG_LEN0:     len0_r = cfg_data[8:0];
          REG_LEN1:     len1_r = cfg_data[8:0];
          REG_CHOICE:   choice_r = cfg_data[3:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) absorb_item(op, channel, table_id, table_index, value);
      if (out_valid && out_ready) check_reading();
    end
    pending = readings_due.size();
  end

endmodule

### bench/testbench.sv
// ----------------------------------------------------------------------------
// Thermistor channel temperature testbench
// Loads both calibration tables, runs directed windows for the clamp and
// acceptance cases, then random phases over several register settings with
// idling on both channels and one long result back-pressure stretch.
// ----------------------------------------------------------------------------
module testbench;
  import tct_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 700;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 op = OP_SAMPLE;
  logic [1:0]           channel = '0;
  logic                 table_id = 1'b0;
  logic [7:0]           table_index = '0;
  logic [9:0]           value = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [1:0]           result_channel;
  logic [9:0]           average;
  logic signed [12:0]   measured_temp;
  logic signed [12:0]   accepted_temp;
  logic                 updated;
  int                   errors;
  int                   pending;

  int send_idle = 0;
  int recv_idle = 0;
  int hold_len = 0;
  int quiet = 0;
  logic [9:0] center [4] = '{10'd163, 10'd400, 10'd600, 10'd800};

  int win_set    [8] = '{3, 5, 0, 64, 4, 127, 6, 3};
  int deb_set    [8] = '{0, 1, 2, 254, 255, 0, 3, 1};
  int len0_set   [8] = '{130, 2, 0, 256, 511, 40, 200, 17};
  int len1_set   [8] = '{92, 256, 1, 300, 2, 60, 129, 255};
  int choice_set [8] = '{0, 15, 5, 10, 3, 12, 9, 6};
  int count_set  [8] = '{220, 170, 220, 150, 110, 110, 170, 170};

  always #2 clk = ~clk;

  thermistor_channel_temperature dut (.*);

  tct_checker u_checker (.*);

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_len > 0) begin
      out_ready <= 1'b0;
      hold_len <= hold_len - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_we || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  function automatic logic [9:0] table_point(logic t, int ix);
    return t ? 10'(258 + 3 * ix) : 10'(100 + 3 * ix);
  endfunction

  // Hold valid across back-to-back transfers; drop it only for a gap.
  task automatic send_item(logic o, logic [1:0] c, logic t, logic [7:0] ix,
                           logic [9:0] v);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= o;
    channel <= c;
    table_id <= t;
    table_index <= ix;
    value <= v;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data[CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_item();
    int roll, jit;
    logic [1:0] c;
    logic t;
    logic [7:0] ix;
    logic [9:0] v;
    roll = $urandom_range(99);
    c = 2'($urandom_range(3));
    t = 1'($urandom_range(1));
    ix = 8'($urandom_range(255));
    if (roll < 8) begin
      // mostly keep the tables ascending so interpolation stays meaningful
      if ($urandom_range(9) == 0) begin
        v = 10'($urandom_range(1023));
      end else begin
        jit = table_point(t, ix) + $urandom_range(2);
        v = (jit > 1023) ? 10'd1023 : jit[9:0];
      end
      send_item(OP_WRITE, c, t, ix, v);
    end else begin
      if ($urandom_range(39) == 0) center[c] = 10'($urandom_range(1023));
      if (roll < 12) v = 10'($urandom_range(1023));
      else if ($urandom_range(3) == 0) v = center[c] ^ 10'($urandom_range(3));
      else v = center[c];
      send_item(OP_SAMPLE, c, t, ix, v);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_reg(REG_WINDOW, 3);
    write_reg(REG_DEBOUNCE, 0);
    write_reg(REG_CHOICE, 4'b1010);

    for (int t = 0; t < 2; t++)
      for (int ix = 0; ix < 256; ix++)
        send_item(OP_WRITE, 2'd0, t[0], ix[7:0], table_point(t[0], ix));

    // below first entry, then a reading of 10 that is still a first acceptance
    repeat (3) send_item(OP_SAMPLE, 2'd0, 1'b0, 8'd0, 10'd0);
    repeat (6) send_item(OP_SAMPLE, 2'd0, 1'b1, 8'd255, 10'd163);
    // at or above the last valid entry of table one
    repeat (3) send_item(OP_SAMPLE, 2'd1, 1'b0, 8'd0, 10'd1023);
    // at or above the last valid entry of table zero, with both field extremes trimmed away
    send_item(OP_SAMPLE, 2'd2, 1'b0, 8'd0, 10'd1023);
    send_item(OP_SAMPLE, 2'd2, 1'b0, 8'd0, 10'd500);
    send_item(OP_SAMPLE, 2'd2, 1'b0, 8'd0, 10'd0);
    repeat (3) send_item(OP_SAMPLE, 2'd3, 1'b0, 8'd0, 10'd258);
    send_item(OP_WRITE, 2'd3, 1'b1, 8'd255, table_point(1'b1, 255));
    send_item(OP_WRITE, 2'd0, 1'b0, 8'd0, table_point(1'b0, 0));

    for (int p = 0; p < 8; p++) begin
      settle();
      write_reg(REG_WINDOW, win_set[p]);
      write_reg(REG_DEBOUNCE, deb_set[p]);
      write_reg(REG_LEN0, len0_set[p]);
      write_reg(REG_LEN1, len1_set[p]);
      write_reg(REG_CHOICE, choice_set[p]);
      if (p < 3) begin
        send_idle = 28;
        recv_idle = 82;
      end else if (p < 6) begin
        send_idle = 82;
        recv_idle = 28;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      if (p == 6) hold_len = 3000;
      repeat (count_set[p]) random_item();
    end

    settle();
    if (errors == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### thermistor_channel_temperature.f
rtl/tct_pkg.sv
rtl/tct_ram.sv
rtl/thermistor_channel_temperature.sv
bench/tct_checker.sv
bench/testbench.sv
